FILE: design/skset_pkg.sv
// Shared types and defaults for the sorted key set.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package skset_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_BITS_DEF   = 16;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [15:0] key;
	} req_t;

	typedef struct packed {
		logic       found;
		logic       inserted;
		logic       full_drop;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic occ;
		logic ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/skset_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the request key
// and takes the key or its lower neighbor's key on an insert. Uses skset_pkg.
`default_nettype none

module skset_cell #(
	parameter int KeyBits = skset_pkg::KEY_BITS_DEF
) (
	input  wire                    clk,
	input  skset_pkg::cell_ctl_t   ctl,
	input  wire  [KeyBits-1:0]     k,
	input  wire                    prev_lt,
	input  wire  [KeyBits-1:0]     prev_key,
	output logic                   lt,
	output logic                   eq,
	output logic [KeyBits-1:0]     key_q
);
	import skset_pkg::*;

	assign lt = ctl.occ && (key_q < k);
	assign eq = ctl.occ && (key_q == k);

	// Slots below the insert position keep their key, the slot at it takes the
	// new key, and the slots above it take the key of the slot below.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			key_q <= prev_lt ? k : prev_key;
		end
	end

endmodule

`default_nettype wire

FILE: design/sorted_key_set_unit.sv
// Top level of the sorted key set: a chain of skset_cell slots, the entry count
// and the result register. Uses skset_pkg and skset_cell.
//
//   channel   | signals                  | direction | payload
//   request   | req_valid, req_stall     | in        | req (req_t)
//   response  | rsp_valid, rsp_stall     | out       | rsp (rsp_t)
//
// For each item, every slot compares its key with the request key in parallel
// and the whole chain shifts in the same cycle, so one item is accepted
// per cycle while the result register is free or being taken.
// The result is registered and appears in the cycle after its item is accepted.
// Reset clears only the entry count and result valid; slot keys are never cleared.
// A stalled result holds the register and stalls the request side.
`default_nettype none

module sorted_key_set_unit #(
	parameter int TableSize = skset_pkg::TABLE_SIZE_DEF,
	parameter int KeyBits   = skset_pkg::KEY_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  skset_pkg::req_t  req,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output skset_pkg::rsp_t  rsp
);
	import skset_pkg::*;

	localparam int CntW = $clog2(TableSize + 1);

	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    count_next;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               acc;
	logic               is_insert;
	logic               found;
	logic               full;
	logic               ins;
	logic [KeyBits-1:0] k;
	logic [TableSize-1:0] lt_w;
	logic [TableSize-1:0] eq_w;
	logic [KeyBits-1:0] key_w [TableSize];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign k         = KeyBits'(req.key);
	assign is_insert = (req.req_type == REQ_INSERT);
	assign found     = |eq_w;
	assign full      = (count_q == CntW'(TableSize));
	assign ins       = acc && is_insert && !found && !full;
	assign count_next = count_q + CntW'(ins);

	genvar i;
	generate
		for (i = 0; i < TableSize; i++) begin : g_cell
			cell_ctl_t          ctl;
			logic               prev_lt;
			logic [KeyBits-1:0] prev_key;

			assign ctl.occ = (CntW'(i) < count_q);
			assign ctl.ins = ins;

			if (i == 0) begin : g_head
				assign prev_lt  = 1'b1;
				assign prev_key = k;
			end else begin : g_body
				assign prev_lt  = lt_w[i-1];
				assign prev_key = key_w[i-1];
			end

			skset_cell #(
				.KeyBits(KeyBits)
			) u_cell (
				.clk(clk),
				.ctl(ctl),
				.k(k),
				.prev_lt(prev_lt),
				.prev_key(prev_key),
				.lt(lt_w[i]),
				.eq(eq_w[i]),
				.key_q(key_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_next;
			end
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.found       <= found;
			rsp_q.inserted    <= ins;
			rsp_q.full_drop   <= is_insert && !found && full;
			rsp_q.entry_count <= 5'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TableSize))
		else $error("entry count exceeds table size");

	a_ins_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.inserted |-> !rsp_q.found && !rsp_q.full_drop)
		else $error("inserted item also flagged found or dropped");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.full_drop |-> rsp_q.entry_count == 5'(TableSize))
		else $error("dropped item without a full table");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid_q)
		else $error("accepted item gave no result");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !ins |=> count_q == $past(count_q))
		else $error("entry count moved without an insert");

endmodule

`default_nettype wire
